// ----- src/dsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dsf_pkg: shared types, constants and float helpers
// Single-precision helpers (round to nearest even) and the power-of-ten table.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int LANES      = 16;
    localparam int MAX_CHARS  = 16;
    localparam int POW_CENTER = 16;
    localparam int POW_SIZE   = 32;

    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_POINT = 8'h2E;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FP_TEN      = 32'h4120_0000;
    localparam logic [31:0] FP_TENTH    = 32'h3DCC_CCCD;

    // control that travels alongside each word
    typedef struct packed {
        logic valid;
        logic negative;
        logic too_long;
    } ctl_t;

    // value = s * mag * 2^(eb - 150); mag may be zero; normal range only
    function automatic logic [31:0] fp_round_pack(input logic s, input logic [47:0] mag,
                                                  input int eb);
        int          lead;
        int          sh;
        int          e;
        logic [47:0] rem;
        logic [47:0] half;
        logic [47:0] kept;
        logic [24:0] m;
        logic        up;
        lead = 0;
        for (int k = 0; k < 48; k++)
        begin
            if (mag[k])
                lead = k;
        end
        up   = 1'b0;
        rem  = '0;
        half = '0;
        if (lead > 23)
        begin
            sh   = lead - 23;
            kept = mag >> sh;
            rem  = mag & ((48'd1 << sh) - 48'd1);
            half = 48'd1 << (sh - 1);
            up   = (rem > half) || ((rem == half) && kept[0]);
        end
        else
        begin
            sh   = 0;
            kept = mag << (23 - lead);
        end
        m = {1'b0, kept[23:0]} + {24'd0, up};
        e = lead + eb - 23 + sh - sh;
        if (m[24])
        begin
            m = m >> 1;
            e = e + 1;
        end
        if (mag == '0)
            return {s, 31'b0};
        return {s, e[7:0], m[22:0]};
    endfunction

    // product of two normal floats (used for the table at elaboration)
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [47:0] prod;
        prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
        if (a[30:23] == 8'd0 || b[30:23] == 8'd0)
            return {a[31] ^ b[31], 31'b0};
        return fp_round_pack(a[31] ^ b[31], prod,
                             int'(a[30:23]) + int'(b[30:23]) - 150);
    endfunction

    // sum of two floats that are zero or normal
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  dexp;
        logic [26:0] mb3;
        logic [26:0] ms3;
        logic [26:0] al;
        logic [27:0] sum;
        logic        lost;
        if (a[30:23] == 8'd0 && b[30:23] == 8'd0)
            return {a[31] & b[31], 31'b0};
        if (a[30:23] == 8'd0)
            return b;
        if (b[30:23] == 8'd0)
            return a;
        if (a[30:0] < b[30:0])
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        dexp = big[30:23] - sml[30:23];
        mb3  = {1'b1, big[22:0], 3'b000};
        ms3  = {1'b1, sml[22:0], 3'b000};
        // align with guard, round and sticky bits
        if (dexp >= 8'd27)
        begin
            al = 27'd1;
        end
        else
        begin
            al    = ms3 >> dexp;
            lost  = |(ms3 & ((27'd1 << dexp) - 27'd1));
            al[0] = al[0] | lost;
        end
        if (big[31] == sml[31])
            sum = {1'b0, mb3} + {1'b0, al};
        else
            sum = {1'b0, mb3} - {1'b0, al};
        if (sum == '0)
            return 32'b0;
        return fp_round_pack(big[31], {20'd0, sum}, int'(big[30:23]) - 3);
    endfunction

    // table entry: 10^(15-k) below the center, 0 at it, 0.1 powers above
    function automatic logic [31:0] pow_entry(input int k);
        logic [31:0] r;
        r = FP_ONE;
        if (k == POW_CENTER)
            return 32'b0;
        if (k < POW_CENTER)
        begin
            for (int j = POW_CENTER - 1; j > k; j--)
                r = fp_mul(r, FP_TEN);
        end
        else
        begin
            for (int j = POW_CENTER + 1; j <= k; j++)
                r = fp_mul(r, FP_TENTH);
        end
        return r;
    endfunction

    function automatic logic [POW_SIZE*32-1:0] pow_flat();
        logic [POW_SIZE*32-1:0] t;
        t = '0;
        for (int k = 0; k < POW_SIZE; k++)
            t[k*32 +: 32] = pow_entry(k);
        return t;
    endfunction

endpackage

// ----- src/dsf_lane.sv -----
// ----------------------------------------------------------------------------
// dsf_lane: one digit lane
// Scales a signed digit by its power of ten; two stages (multiply, round).
// ----------------------------------------------------------------------------
module dsf_lane (
    input  logic              clk,
    input  logic signed [7:0] digit,
    input  logic [4:0]        pow_idx,
    output logic [31:0]       lane_val
);
    import dsf_pkg::*;

    localparam logic [POW_SIZE*32-1:0] POW_TAB = pow_flat();

    logic [31:0] pw;
    logic [7:0]  dmag;
    logic [31:0] prod_next;
    logic [31:0] prod_reg;
    logic [7:0]  exp_reg;
    logic        sign_reg;
    logic        zero_reg;
    logic [31:0] val_reg;

    // table lookup and integer multiply
    always_comb
    begin
        pw        = POW_TAB[{pow_idx, 5'b0} +: 32];
        dmag      = digit[7] ? 8'(-digit) : 8'(digit);
        prod_next = {24'd0, dmag} * {8'd0, 1'b1, pw[22:0]};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        exp_reg  <= pw[30:23];
        sign_reg <= digit[7];
        zero_reg <= (digit == 8'sd0) || (pw[30:23] == 8'd0);
    end

    // normalize and round
    always_ff @(posedge clk)
    begin
        if (zero_reg)
            val_reg <= {sign_reg, 31'b0};
        else
            val_reg <= fp_round_pack(sign_reg, {16'd0, prod_reg}, int'(exp_reg));
    end

    assign lane_val = val_reg;

endmodule

// ----- src/dsf_merge.sv -----
// ----------------------------------------------------------------------------
// dsf_merge: pairwise adder tree
// Sums the lanes as i+8, i+4, i+2, i+1; one register level per tree level.
// ----------------------------------------------------------------------------
module dsf_merge (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   lane_val [dsf_pkg::LANES],
    input  dsf_pkg::ctl_t ctl_in,
    output logic [31:0]   sum,
    output dsf_pkg::ctl_t ctl_out
);
    import dsf_pkg::*;

    logic [31:0] l1_reg [8];
    logic [31:0] l2_reg [4];
    logic [31:0] l3_reg [2];
    logic [31:0] l4_reg;
    ctl_t        ctl_reg [4];

    // tree levels
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
            l1_reg[i] <= fp_add(lane_val[i], lane_val[i+8]);
        for (int i = 0; i < 4; i++)
            l2_reg[i] <= fp_add(l1_reg[i], l1_reg[i+4]);
        for (int i = 0; i < 2; i++)
            l3_reg[i] <= fp_add(l2_reg[i], l2_reg[i+2]);
        l4_reg <= fp_add(l3_reg[0], l3_reg[1]);
    end

    // control follows the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                ctl_reg[i] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < 4; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    assign sum     = l4_reg;
    assign ctl_out = ctl_reg[3];

endmodule

// ----- src/decimal_string_to_float.sv -----
// ----------------------------------------------------------------------------
// decimal_string_to_float: decimal string body to single-precision float
// Sixteen digit lanes scaled by powers of ten, summed in a fixed tree.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word (negative, body_length, chars_low, chars_high) with start
//   high; it is taken at any edge where start is high, and busy is always
//   low, so a new word may follow every cycle.
//   done pulses for one cycle with value_bits and
//   too_long. Results leave in the order words came in.
//   Throughput is one word per cycle. Each word passes the decode register,
//   lane multiply, lane round, four adder tree levels and the output register.
//   The receiver cannot stall the block; a result is shown exactly once.
//   too_long is set when body_length exceeds 16; value_bits is then zero.
//   Reset clears all valid flags; words in flight are dropped.
// ----------------------------------------------------------------------------
module decimal_string_to_float (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        negative,
    input  logic [7:0]  body_length,
    input  logic [63:0] chars_low,
    input  logic [63:0] chars_high,
    output logic        done,
    output logic [31:0] value_bits,
    output logic        too_long
);
    import dsf_pkg::*;

    logic [127:0]      chars;
    logic [4:0]        pnt;
    logic              found;
    logic              tl;
    logic signed [7:0] digit_next [LANES];
    logic [4:0]        idx_next   [LANES];
    logic signed [7:0] digit_reg  [LANES];
    logic [4:0]        idx_reg    [LANES];
    logic [31:0]       lane_val   [LANES];
    ctl_t              ctl_reg    [3];
    ctl_t              ctl_m;
    logic [31:0]       sum;
    logic              done_reg;
    logic [31:0]       value_reg;
    logic              tl_reg;

    assign busy  = 1'b0;
    assign chars = {chars_high, chars_low};
    assign tl    = body_length > 8'(MAX_CHARS);

    // point search and lane decode
    always_comb
    begin
        pnt   = tl ? 5'd0 : body_length[4:0];
        found = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (!found && (8'(i) < body_length) && (chars[i*8 +: 8] == ASCII_POINT))
            begin
                pnt   = 5'(i);
                found = 1'b1;
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            digit_next[i] = (8'(i) < body_length) ? (chars[i*8 +: 8] - ASCII_ZERO) : 8'd0;
            idx_next[i]   = 5'(6'(POW_CENTER) - {1'b0, pnt} + 6'(i));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            digit_reg[i] <= digit_next[i];
            idx_reg[i]   <= idx_next[i];
        end
    end

    // control through decode and lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                ctl_reg[i] <= '0;
        end
        else
        begin
            ctl_reg[0] <= '{valid: start && !busy, negative: negative, too_long: tl};
            ctl_reg[1] <= ctl_reg[0];
            ctl_reg[2] <= ctl_reg[1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            dsf_lane u_lane (
                .clk      (clk),
                .digit    (digit_reg[g]),
                .pow_idx  (idx_reg[g]),
                .lane_val (lane_val[g])
            );
        end
    endgenerate

    dsf_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .lane_val (lane_val),
        .ctl_in   (ctl_reg[2]),
        .sum      (sum),
        .ctl_out  (ctl_m)
    );

    // sign and too-long handling, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_m.valid;
    end

    always_ff @(posedge clk)
    begin
        tl_reg    <= ctl_m.too_long;
        value_reg <= ctl_m.too_long ? 32'd0 : {sum[31] ^ ctl_m.negative, sum[30:0]};
    end

    assign done       = done_reg;
    assign value_bits = value_reg;
    assign too_long   = tl_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##8 done)
        else $error("accepted word did not complete in 8 cycles");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 8))
        else $error("result without a matching word");
    a_tl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && too_long) |-> (value_bits == 32'd0))
        else $error("too_long result with nonzero value");
    a_tl_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (too_long == ($past(body_length, 8) > 8'(MAX_CHARS))))
        else $error("too_long does not match body length");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for decimal_string_to_float
// Sends string bodies (directed corner cases, then random words under three
// sender gap profiles). A float predictor works out each expected word. Every
// done pulse is checked against the oldest expected word.
// ----------------------------------------------------------------------------
module testbench;
    import dsf_pkg::*;

    localparam int LATENCY = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        negative;
    logic [7:0]  body_length;
    logic [63:0] chars_low;
    logic [63:0] chars_high;
    logic        done;
    logic [31:0] value_bits;
    logic        too_long;

    // expected result words, oldest first
    logic [31:0] want_value_q[$];
    logic        want_long_q[$];
    int          errors;
    int          idle_pct;

    decimal_string_to_float dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .negative   (negative),
        .body_length(body_length),
        .chars_low  (chars_low),
        .chars_high (chars_high),
        .done       (done),
        .value_bits (value_bits),
        .too_long   (too_long)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // single-precision bits to real (zero or normal only)
    function automatic real sp_to_real(input logic [31:0] f);
        logic [10:0] e;
        if (f[30:23] == 8'd0)
            return $bitstoreal({f[31], 63'b0});
        e = 11'(int'(f[30:23]) - 127 + 1023);
        return $bitstoreal({f[31], e, f[22:0], 29'b0});
    endfunction

    // real to single-precision bits, round to nearest even
    function automatic logic [31:0] real_to_sp(input real x);
        logic [63:0] d;
        logic [52:0] m;
        logic [24:0] kept;
        logic [28:0] rem;
        int          e;
        d = $realtobits(x);
        if (d[62:52] == 11'd0)
            return {d[63], 31'b0};
        m    = {1'b1, d[51:0]};
        kept = {1'b0, m[52:29]};
        rem  = m[28:0];
        e    = int'(d[62:52]) - 1023 + 127;
        if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && kept[0]))
            kept = kept + 25'd1;
        if (kept[24])
        begin
            kept = kept >> 1;
            e    = e + 1;
        end
        return {d[63], e[7:0], kept[22:0]};
    endfunction

    // float multiply and add: double holds these exactly enough for one rounding
    function automatic real sp_mul(input real a, input real b);
        return sp_to_real(real_to_sp(a * b));
    endfunction

    function automatic real sp_add(input real a, input real b);
        return sp_to_real(real_to_sp(a + b));
    endfunction

    // scale factor for table slot k: tens below center, zero at it, tenths above
    function automatic real scale_at(input int k);
        real r;
        real tenth;
        r     = 1.0;
        tenth = sp_to_real(32'h3DCC_CCCD);
        if (k == POW_CENTER)
            return 0.0;
        if (k < POW_CENTER)
        begin
            for (int j = POW_CENTER - 1; j > k; j--)
                r = sp_mul(r, 10.0);
        end
        else
        begin
            for (int j = POW_CENTER + 1; j <= k; j++)
                r = sp_mul(r, tenth);
        end
        return r;
    endfunction

    // expected word for one string body
    task automatic predict_float(input logic neg, input logic [7:0] len,
                                 input logic [127:0] body,
                                 output logic [31:0] vbits, output logic tl);
        real         lane[LANES];
        int          pt;
        int          d;
        logic [7:0]  b;
        logic [7:0]  db;
        if (len > 8'(MAX_CHARS))
        begin
            vbits = 32'b0;
            tl    = 1'b1;
            return;
        end
        tl = 1'b0;
        pt = len;
        for (int i = len - 1; i >= 0; i--)
        begin
            if (body[i*8 +: 8] == ASCII_POINT)
                pt = i;
        end
        for (int i = 0; i < LANES; i++)
        begin
            d = 0;
            if (i < len)
            begin
                b  = body[i*8 +: 8];
                db = b - ASCII_ZERO;
                d  = int'($signed(db));
            end
            lane[i] = sp_mul(real'(d), scale_at((POW_CENTER - pt + i) & (POW_SIZE - 1)));
        end
        for (int h = LANES / 2; h >= 1; h = h / 2)
        begin
            for (int i = 0; i < h; i++)
                lane[i] = sp_add(lane[i], lane[i + h]);
        end
        vbits = real_to_sp(lane[0]);
        if (neg)
            vbits[31] = ~vbits[31];
    endtask

    // send one word; sender may idle first
    task automatic send_word(input logic neg, input int len, input logic [127:0] body);
        logic [31:0] v;
        logic        tl;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        negative    <= neg;
        body_length <= 8'(len);
        chars_low   <= body[63:0];
        chars_high  <= body[127:64];
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        predict_float(neg, 8'(len), body, v, tl);
        want_value_q.push_back(v);
        want_long_q.push_back(tl);
        @(posedge clk);
    endtask

    // let everything in flight come out
    task automatic drain();
        start <= 1'b0;
        while (want_value_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            r[i*8 +: 8] = s[i];
        return r;
    endfunction

    task automatic send_text(input logic neg, input string s);
        send_word(neg, s.len(), pack_text(s));
    endtask

    // corner cases: empty, full width, points, odd bytes, too long
    task automatic test_corner_cases();
        idle_pct = 0;
        send_text(1'b0, "");
        send_text(1'b1, "");
        send_text(1'b0, "9999999999999999");
        send_text(1'b1, "9999999999999999");
        send_text(1'b0, "0000000000000000");
        send_text(1'b1, "0");
        send_text(1'b0, ".");
        send_text(1'b0, ".123456789012345");
        send_text(1'b1, "123456789012345.");
        send_text(1'b0, "3.14159265358979");
        send_text(1'b0, "1.2.3");
        send_text(1'b0, "..5");
        send_text(1'b0, "0.5");
        send_text(1'b1, "12ab.z9");
        send_word(1'b0, 16, {16{8'h00}});
        send_word(1'b1, 16, {16{8'hFF}});
        send_word(1'b0, 3, {{13{8'hFF}}, 8'h31, 8'h2E, 8'h37});
        send_word(1'b0, 17, {16{8'h35}});
        send_word(1'b1, 255, {16{8'hA5}});
        send_word(1'b0, 128, '1);
        send_text(1'b0, "1");
        send_text(1'b0, "7654321");
        drain();
    endtask

    // random words: mostly well formed numbers, some noise, a few too long
    task automatic random_words(input int count);
        logic [127:0] body;
        int           len;
        int           kind;
        int           npt;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            body = {$urandom(), $urandom(), $urandom(), $urandom()};
            len  = ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(16);
            if (kind < 70)
            begin
                for (int i = 0; i < len; i++)
                    body[i*8 +: 8] = ASCII_ZERO + 8'($urandom_range(9));
                npt = ($urandom_range(9) < 6) ? 1 : $urandom_range(2);
                for (int k = 0; k < npt && len > 0; k++)
                    body[$urandom_range(len - 1)*8 +: 8] = ASCII_POINT;
            end
            else if (kind < 85)
            begin
                for (int i = 0; i < len; i++)
                    if ($urandom_range(3) != 0)
                        body[i*8 +: 8] = ASCII_ZERO + 8'($urandom_range(9));
            end
            else if (kind >= 95)
            begin
                len = $urandom_range(255, 17);
            end
            send_word(1'($urandom_range(1)), len, body);
        end
    endtask

    task automatic test_sender_gaps();
        idle_pct = 23;
        random_words(430);
        drain();
    endtask

    task automatic test_sparse_sender();
        idle_pct = 88;
        random_words(430);
        drain();
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        random_words(440);
        drain();
    endtask

    // compare each done pulse with the oldest expected word
    always @(posedge clk)
    begin
        logic [31:0] wv;
        logic        wl;
        if (rst_n && done)
        begin
            if (want_value_q.size() == 0)
            begin
                $error("unexpected result word value_bits=%h too_long=%b",
                       value_bits, too_long);
                errors++;
            end
            else
            begin
                wv = want_value_q.pop_front();
                wl = want_long_q.pop_front();
                if (value_bits !== wv)
                begin
                    $error("value_bits expected %h actual %h", wv, value_bits);
                    errors++;
                end
                if (too_long !== wl)
                begin
                    $error("too_long expected %b actual %b", wl, too_long);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[decimal_string_to_float] ERROR");
        $finish;
    end

    initial
    begin
        errors      = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        negative    = 1'b0;
        body_length = 8'd0;
        chars_low   = 64'd0;
        chars_high  = 64'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_cases();
        test_sender_gaps();
        test_sparse_sender();
        test_back_to_back();
        if (errors == 0 && want_value_q.size() == 0)
            $display("[decimal_string_to_float] OK");
        else
            $display("[decimal_string_to_float] ERROR");
        $finish;
    end

endmodule
